// ----- sv/pds_pkg.sv -----
package pds_pkg;

  // Width of the frequency input fields.
  localparam int FREQ_BITS = 29;
  // Target times the largest R (8) needs three more bits.
  localparam int VREQ_W    = FREQ_BITS + 3;
  localparam int DIV_W     = VREQ_W;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int VIN_LIM_W = 29;
  localparam int VOUT_W    = 32;
  localparam int MULT_W    = 9;
  localparam int DIVM_W    = 4;
  localparam int DIVRQ_W   = 4;
  localparam int ERR_W     = 32;
  localparam int USB_W     = 29;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [DIV_CNT_W-1:0] ITERS_VIN = DIV_CNT_W'(DIV_W);
  localparam logic [DIV_CNT_W-1:0] ITERS_N   = DIV_CNT_W'(MULT_W);

  // Reciprocal of three: (x * RECIP3) >> 33 equals x / 3 for any 32-bit x.
  localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;
  localparam int RECIP3_SHIFT = 33;

  localparam logic [ERR_W-1:0] ERR_NONE = '1;

  typedef struct packed {
    logic [FREQ_BITS-1:0] ref_freq;
    logic [FREQ_BITS-1:0] goal_freq;
  } in_t;

  typedef struct packed {
    logic               found;
    logic [DIVM_W-1:0]  div_m;
    logic [MULT_W-1:0]  mult_n;
    logic [DIVRQ_W-1:0] div_r;
    logic [DIVRQ_W-1:0] div_q;
    logic [ERR_W-1:0]   freq_error;
  } out_t;

  typedef struct packed {
    logic [VIN_LIM_W-1:0] vco_in_min;
    logic [VIN_LIM_W-1:0] vco_in_max;
    logic [VOUT_W-1:0]    vco_out_min;
    logic [VOUT_W-1:0]    vco_out_max;
    logic [MULT_W-1:0]    mult_min;
    logic [MULT_W-1:0]    mult_max;
    logic [DIVM_W-1:0]    div_m_max;
    logic [USB_W-1:0]     usb_freq;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    vco_in_min:  29'd4000000,
    vco_in_max:  29'd16000000,
    vco_out_min: 32'd64000000,
    vco_out_max: 32'd344000000,
    mult_min:    9'd8,
    mult_max:    9'd86,
    div_m_max:   4'd8,
    usb_freq:    29'd48000000
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VCO_IN_MIN  = 3'd0,
    CFG_VCO_IN_MAX  = 3'd1,
    CFG_VCO_OUT_MIN = 3'd2,
    CFG_VCO_OUT_MAX = 3'd3,
    CFG_MULT_MIN    = 3'd4,
    CFG_MULT_MAX    = 3'd5,
    CFG_DIV_M_MAX   = 3'd6,
    CFG_USB_FREQ    = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_M_CHECK,
    ST_VIN_WAIT,
    ST_VIN_CHECK,
    ST_R_CHECK,
    ST_N_WAIT,
    ST_N_CHECK,
    ST_SYS,
    ST_ERR,
    ST_DONE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_item;
    logic div_vin;
    logic div_n;
    logic latch_vin;
    logic latch_n;
    logic load_vact;
    logic load_sys;
    logic try_best;
    logic m_inc;
    logic r_clear;
    logic r_inc;
    logic load_out;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic zero_in;
    logic m_over;
    logic vin_ok;
    logic vreq_ok;
    logic n_ok;
    logic r_last;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ----- sv/pds_div.sv -----
module pds_div import pds_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_W-1:0]     dividend,
  input  logic [DIV_W-1:0]     rem_init,
  input  logic [DIV_W-1:0]     divisor,
  input  logic [DIV_CNT_W-1:0] iters,
  output logic                 done,
  output logic [DIV_W-1:0]     quotient
);

  // Restoring division, one quotient bit per cycle. The dividend shifts out
  // of the top of quo_r while quotient bits shift in at the bottom.
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     rem_r;
  logic [DIV_W-1:0]     quo_r;
  logic [DIV_W-1:0]     dsr_r;

  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             fits;
  logic [DIV_W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[DIV_W-1]};
    diff    = trial - {1'b0, dsr_r};
    fits    = trial >= {1'b0, dsr_r};
    rem_nxt = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= iters;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- sv/pds_datapath.sv -----
module pds_datapath import pds_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  in_t  in_data,
  input  cmd_t cmd,
  output sts_t sts,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic [FREQ_BITS-1:0] ref_r;
  logic [FREQ_BITS-1:0] tgt_r;
  logic [DIVM_W:0]      m_r;
  logic [1:0]           ridx_r;
  logic [FREQ_BITS-1:0] vin_r;
  logic [MULT_W-1:0]    n_r;
  logic [VREQ_W-1:0]    vact_r;
  logic [VREQ_W-1:0]    sys_r;
  logic [DIVRQ_W-1:0]   q_r;
  logic [VOUT_W-1:0]    usb3_r;
  logic [VOUT_W-1:0]    usb5_r;
  logic [VOUT_W-1:0]    usb7_r;

  logic                 found_r;
  logic [DIVM_W-1:0]    best_m_r;
  logic [MULT_W-1:0]    best_n_r;
  logic [DIVRQ_W-1:0]   best_r_r;
  logic [DIVRQ_W-1:0]   best_q_r;
  logic [ERR_W-1:0]     best_err_r;

  logic                 out_valid_r;
  out_t                 out_r;

  logic [DIVRQ_W-1:0]   r_val;
  logic [VREQ_W-1:0]    vreq;
  logic [VREQ_W-1:0]    sys_nxt;
  logic [DIVRQ_W-1:0]   q_nxt;
  logic [63:0]          prod3;
  logic [ERR_W-1:0]     err;
  logic [ERR_W-1:0]     tgt_ext;
  logic [ERR_W-1:0]     sys_ext;
  logic [VOUT_W-1:0]    usb_ext;

  logic                 div_done;
  logic [DIV_W-1:0]     div_quo;
  logic [DIV_W-1:0]     div_dividend;
  logic [DIV_W-1:0]     div_rem_init;
  logic [DIV_W-1:0]     div_divisor;
  logic [DIV_CNT_W-1:0] div_iters;

  // R runs 2, 4, 6, 8 as ridx_r runs 0 to 3.
  assign r_val = {1'b0, ridx_r, 1'b0} + DIVRQ_W'(2);
  assign vreq  = VREQ_W'(tgt_r * r_val);

  // One divider serves both ref / M and the N quotient. The N division
  // starts from the top bits of vreq, so only nine quotient bits remain.
  always_comb begin
    if (cmd.div_n) begin
      div_dividend = {vreq[MULT_W-1:0], {(DIV_W - MULT_W){1'b0}}};
      div_rem_init = DIV_W'(vreq[VREQ_W-1:MULT_W]);
      div_divisor  = DIV_W'(vin_r);
      div_iters    = ITERS_N;
    end else begin
      div_dividend = DIV_W'(ref_r);
      div_rem_init = '0;
      div_divisor  = DIV_W'(m_r[DIVM_W-1:0]);
      div_iters    = ITERS_VIN;
    end
  end

  pds_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_vin | cmd.div_n),
    .dividend (div_dividend),
    .rem_init (div_rem_init),
    .divisor  (div_divisor),
    .iters    (div_iters),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Multiples of the USB frequency that set the Q thresholds.
  assign usb_ext = VOUT_W'(cfg.usb_freq);

  always_ff @(posedge clk) begin
    usb3_r <= (usb_ext << 1) + usb_ext;
    usb5_r <= (usb_ext << 2) + usb_ext;
    usb7_r <= (usb_ext << 3) - usb_ext;
  end

  always_comb begin
    prod3 = {32'd0, VREQ_W'(vact_r >> 1)} * {32'd0, RECIP3};
    case (ridx_r)
      2'd0:    sys_nxt = vact_r >> 1;
      2'd1:    sys_nxt = vact_r >> 2;
      2'd2:    sys_nxt = VREQ_W'(prod3 >> RECIP3_SHIFT);
      default: sys_nxt = vact_r >> 3;
    endcase
    if (vact_r >= usb7_r) begin
      q_nxt = DIVRQ_W'(8);
    end else if (vact_r >= usb5_r) begin
      q_nxt = DIVRQ_W'(6);
    end else if (vact_r >= usb3_r) begin
      q_nxt = DIVRQ_W'(4);
    end else begin
      q_nxt = DIVRQ_W'(2);
    end
  end

  assign tgt_ext = ERR_W'(tgt_r);
  assign sys_ext = ERR_W'(sys_r);
  assign err     = (sys_ext > tgt_ext) ? (sys_ext - tgt_ext) : (tgt_ext - sys_ext);

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      ref_r <= in_data.ref_freq;
      tgt_r <= in_data.goal_freq;
    end
    if (cmd.load_item) begin
      m_r <= (DIVM_W + 1)'(1);
    end else if (cmd.m_inc) begin
      m_r <= m_r + 1'b1;
    end
    if (cmd.r_clear) begin
      ridx_r <= '0;
    end else if (cmd.r_inc) begin
      ridx_r <= ridx_r + 1'b1;
    end
    if (cmd.latch_vin) begin
      vin_r <= div_quo[FREQ_BITS-1:0];
    end
    if (cmd.latch_n) begin
      n_r <= div_quo[MULT_W-1:0];
    end
    if (cmd.load_vact) begin
      vact_r <= VREQ_W'(vin_r * n_r);
    end
    if (cmd.load_sys) begin
      sys_r <= sys_nxt;
      q_r   <= q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.load_item) begin
      found_r <= 1'b0;
    end else if (cmd.try_best && (err < best_err_r)) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      best_err_r <= ERR_NONE;
      best_m_r   <= '0;
      best_n_r   <= '0;
      best_r_r   <= '0;
      best_q_r   <= '0;
    end else if (cmd.try_best && (err < best_err_r)) begin
      best_err_r <= err;
      best_m_r   <= m_r[DIVM_W-1:0];
      best_n_r   <= n_r;
      best_r_r   <= r_val;
      best_q_r   <= q_r;
    end
  end

  // Output register: the next item may be searched while this one waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r <= '{found: found_r, div_m: best_m_r, mult_n: best_n_r, div_r: best_r_r,
                 div_q: best_q_r, freq_error: best_err_r};
    end
  end

  always_comb begin
    sts.zero_in  = (ref_r == '0) || (tgt_r == '0);
    sts.m_over   = m_r > {1'b0, cfg.div_m_max};
    sts.vin_ok   = (vin_r != '0) && (vin_r >= cfg.vco_in_min) && (vin_r <= cfg.vco_in_max);
    // A quotient of 512 or more can never pass the N limits.
    sts.vreq_ok  = (vreq >= cfg.vco_out_min) && (vreq <= cfg.vco_out_max) &&
                   (FREQ_BITS'(vreq[VREQ_W-1:MULT_W]) < vin_r);
    sts.n_ok     = (n_r >= cfg.mult_min) && (n_r <= cfg.mult_max);
    sts.r_last   = ridx_r == 2'd3;
    sts.div_done = div_done;
    sts.out_free = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- sv/pds_ctrl.sv -----
module pds_ctrl import pds_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_M_CHECK;
      end
      ST_M_CHECK: begin
        if (sts.zero_in || sts.m_over) state_nxt = ST_DONE;
        else state_nxt = ST_VIN_WAIT;
      end
      ST_VIN_WAIT: begin
        if (sts.div_done) state_nxt = ST_VIN_CHECK;
      end
      ST_VIN_CHECK: begin
        state_nxt = sts.vin_ok ? ST_R_CHECK : ST_M_CHECK;
      end
      ST_R_CHECK: begin
        if (sts.vreq_ok) state_nxt = ST_N_WAIT;
        else if (sts.r_last) state_nxt = ST_M_CHECK;
      end
      ST_N_WAIT: begin
        if (sts.div_done) state_nxt = ST_N_CHECK;
      end
      ST_N_CHECK: begin
        if (sts.n_ok) state_nxt = ST_SYS;
        else state_nxt = sts.r_last ? ST_M_CHECK : ST_R_CHECK;
      end
      ST_SYS: begin
        state_nxt = ST_ERR;
      end
      ST_ERR: begin
        state_nxt = sts.r_last ? ST_M_CHECK : ST_R_CHECK;
      end
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_M_CHECK: begin
        cmd.div_vin = !(sts.zero_in || sts.m_over);
      end
      ST_VIN_WAIT: begin
        cmd.latch_vin = sts.div_done;
      end
      ST_VIN_CHECK: begin
        cmd.r_clear = sts.vin_ok;
        cmd.m_inc   = !sts.vin_ok;
      end
      ST_R_CHECK: begin
        cmd.div_n = sts.vreq_ok;
        cmd.r_inc = !sts.vreq_ok && !sts.r_last;
        cmd.m_inc = !sts.vreq_ok && sts.r_last;
      end
      ST_N_WAIT: begin
        cmd.latch_n = sts.div_done;
      end
      ST_N_CHECK: begin
        cmd.load_vact = sts.n_ok;
        cmd.r_inc     = !sts.n_ok && !sts.r_last;
        cmd.m_inc     = !sts.n_ok && sts.r_last;
      end
      ST_SYS: begin
        cmd.load_sys = 1'b1;
      end
      ST_ERR: begin
        cmd.try_best = 1'b1;
        cmd.r_inc    = !sts.r_last;
        cmd.m_inc    = sts.r_last;
      end
      ST_DONE: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- sv/pll_divider_search.sv -----
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_t: ref_freq, goal_freq
// out_      output     out_valid / out_ready  out_t: found, div_m, mult_n, div_r, div_q,
//                                             freq_error
// cfg_      input      cfg_we                 cfg_index selects a register, cfg_wdata
//
// One transaction is searched at a time. Each M tried runs the 32-step division ref / M on the
// shared bit-serial divider, then checks each R under an allowed VCO input. A pair that
// passes the VCO output check also waits on the nine-step N division on the same divider.
// In the worst case M runs up to 15.
// Reset is synchronous and active low; it clears the controller, the divider control and
// the output valid, and reloads the configuration registers with their default values.
// A finished result sits in an output register, so in_ready returns while that result
// waits; a stalled out_ready holds only the end of the following search.
module pll_divider_search import pds_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;

  // Configuration register file. Each write keeps the low bits that the register holds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_VCO_IN_MIN:  cfg_r.vco_in_min  <= cfg_wdata[VIN_LIM_W-1:0];
        CFG_VCO_IN_MAX:  cfg_r.vco_in_max  <= cfg_wdata[VIN_LIM_W-1:0];
        CFG_VCO_OUT_MIN: cfg_r.vco_out_min <= cfg_wdata[VOUT_W-1:0];
        CFG_VCO_OUT_MAX: cfg_r.vco_out_max <= cfg_wdata[VOUT_W-1:0];
        CFG_MULT_MIN:    cfg_r.mult_min    <= cfg_wdata[MULT_W-1:0];
        CFG_MULT_MAX:    cfg_r.mult_max    <= cfg_wdata[MULT_W-1:0];
        CFG_DIV_M_MAX:   cfg_r.div_m_max   <= cfg_wdata[DIVM_W-1:0];
        CFG_USB_FREQ:    cfg_r.usb_freq    <= cfg_wdata[USB_W-1:0];
        default:         cfg_r             <= cfg_r;
      endcase
    end
  end

  // The controller walks M outer and R inner, in the same order as the search is
  // defined, so the first candidate with the smallest error is the one kept.
  pds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the divider, the multiply steps, the best candidate so far
  // and the output register.
  pds_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A search never starts in the cycle after one was taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a search was still running");

  // A result is never written over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("output register overwritten before it was taken");

  // A miss reports zero dividers and the all-ones error.
  a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |->
      (out_data.div_m == '0 && out_data.mult_n == '0 && out_data.div_r == '0 &&
       out_data.div_q == '0 && out_data.freq_error == ERR_NONE))
    else $error("result without a candidate carries nonzero dividers");

  // A hit reports an even R and Q from two to eight and a nonzero M.
  a_hit_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.found) |->
      (out_data.div_m != '0 &&
       (out_data.div_r == 4'd2 || out_data.div_r == 4'd4 ||
        out_data.div_r == 4'd6 || out_data.div_r == 4'd8) &&
       (out_data.div_q == 4'd2 || out_data.div_q == 4'd4 ||
        out_data.div_q == 4'd6 || out_data.div_q == 4'd8)))
    else $error("found result carries an illegal divider");

endmodule
